// ===== hdl/vertex_normal_smoother_macros.svh =====
// ----------------------------------------------------------------------------
// vertex_normal_smoother_macros.svh
// Assertion macros used by the checker file of the smoother.
// ----------------------------------------------------------------------------
`ifndef VERTEX_NORMAL_SMOOTHER_MACROS_SVH
`define VERTEX_NORMAL_SMOOTHER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define VNS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a signal holds while its channel is stalled.
`define VNS_ASSERT_HOLD(name, clk, rst_n, vld, stl, sig, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && stl) |=> $stable(sig)) else $error(msg);

`endif

// ===== hdl/vns_pkg.sv =====
// ----------------------------------------------------------------------------
// vns_pkg
// Types and constants of the vertex normal smoother.
// ----------------------------------------------------------------------------
package vns_pkg;

  localparam int unsigned MaxVerticesDef = 64;
  localparam int unsigned NumComp       = 3;
  localparam int unsigned RootBits      = 15;
  localparam logic [3:0]  TopBit        = 4'd14;
  localparam int unsigned SumW          = 23;
  localparam int unsigned MagW          = 22;
  localparam int unsigned SqW           = 43;
  localparam int unsigned DotW          = 44;
  localparam int unsigned DotHalf       = 22;

  typedef struct packed {
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic [31:0]        pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic               last_vertex;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               out_last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RD_I,
    ST_LAT_I,
    ST_SCAN,
    ST_DRAIN,
    ST_SQ,
    ST_DSUM,
    ST_T2,
    ST_MUL,
    ST_CMP,
    ST_OUT
  } vns_state_e;

  typedef struct packed {
    logic       wr_en;
    logic       latch_i;
    logic       acc_clr;
    logic       scan_rd;
    logic       sq_en;
    logic       dsum_en;
    logic       r_clr;
    logic       t2_en;
    logic       mul_en;
    logic       cmp_en;
    logic       out_load;
    logic       out_last;
    logic [1:0] comp;
    logic [3:0] bit_idx;
  } vns_cmd_t;

endpackage

// ===== hdl/vertex_normal_smoother.sv =====
// ----------------------------------------------------------------------------
// vertex_normal_smoother
// Smooths vertex normals over vertices that share a bit-identical position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one vertex per
//   cycle while loading. Vertices past MAX_VERTICES are dropped. The item
//   flagged last_vertex starts a run; input stalls until the run is done.
//   Output channel (out_valid_o / out_stall_i / out_item_o) gives one result
//   per loaded vertex, in load order, out_last set on the final one.
//   Per result: the vertex is fetched, the scan makes one memory read per
//   stored vertex, the scan drains, the sums are squared and added to the
//   dot product, then the root search runs 3 components x 15 bits x 3 steps
//   of the shared multiplier pair, and the result is handed over.
//   A stalled output holds its item; the next result is computed meanwhile
//   and waits in the sequencer until the output register frees up.
//   Reset empties the vertex count and output register; memories need none.
// ----------------------------------------------------------------------------
module vertex_normal_smoother import vns_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MaxVerticesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  vns_cmd_t      cmd;

  vns_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .AW           (AW),
    .CW           (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_item_i.last_vertex),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .wr_addr_o   (wr_addr),
    .rd_addr_o   (rd_addr),
    .cmd_o       (cmd)
  );

  vns_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .AW           (AW)
  ) u_dp (
    .clk_i      (clk_i),
    .in_item_i  (in_item_i),
    .wr_addr_i  (wr_addr),
    .rd_addr_i  (rd_addr),
    .cmd_i      (cmd),
    .out_item_o (out_item_o)
  );

endmodule

// ===== hdl/vns_ctrl.sv =====
// ----------------------------------------------------------------------------
// vns_ctrl
// Sequencer: load counting, group scan, root search steps, result hand-off.
// ----------------------------------------------------------------------------
module vns_ctrl import vns_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MaxVerticesDef,
  parameter int unsigned AW = $clog2(MAX_VERTICES),
  parameter int unsigned CW = $clog2(MAX_VERTICES + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [AW-1:0] wr_addr_o,
  output logic [AW-1:0] rd_addr_o,
  output vns_cmd_t      cmd_o
);

  vns_state_e    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] i_q, i_d;
  logic [AW-1:0] j_q, j_d;
  logic [1:0]    comp_q, comp_d;
  logic [3:0]    bit_q, bit_d;
  logic          out_valid_q, out_valid_d;
  logic          in_acc;
  logic          j_last;
  logic          i_last;

  // State and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      comp_q      <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      i_q         <= i_d;
      j_q         <= j_d;
      comp_q      <= comp_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_LOAD);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign wr_addr_o   = cnt_q[AW-1:0];
  assign rd_addr_o   = (state_q == ST_SCAN) ? j_q : i_q;
  assign j_last      = (CW'(j_q) == (cnt_q - CW'(1)));
  assign i_last      = (CW'(i_q) == (cnt_q - CW'(1)));

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    comp_d      = comp_q;
    bit_d       = bit_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o          = '0;
    cmd_o.comp     = comp_q;
    cmd_o.bit_idx  = bit_q;
    cmd_o.out_last = i_last;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_q < CW'(MAX_VERTICES)) begin
            cmd_o.wr_en = 1'b1;
            cnt_d       = cnt_q + CW'(1);
          end
          if (in_last_i) begin
            i_d     = '0;
            state_d = ST_RD_I;
          end
        end
      end
      ST_RD_I: begin
        cmd_o.acc_clr = 1'b1;
        state_d       = ST_LAT_I;
      end
      ST_LAT_I: begin
        cmd_o.latch_i = 1'b1;
        j_d           = '0;
        state_d       = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (j_last) begin
          state_d = ST_DRAIN;
        end else begin
          j_d = j_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        comp_d  = '0;
        state_d = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.sq_en = 1'b1;
        if (comp_q == 2'd2) begin
          state_d = ST_DSUM;
        end else begin
          comp_d = comp_q + 2'd1;
        end
      end
      ST_DSUM: begin
        cmd_o.dsum_en = 1'b1;
        cmd_o.r_clr   = 1'b1;
        comp_d        = '0;
        bit_d         = TopBit;
        state_d       = ST_T2;
      end
      ST_T2: begin
        cmd_o.t2_en = 1'b1;
        state_d     = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.cmp_en = 1'b1;
        if (bit_q != 4'd0) begin
          bit_d   = bit_q - 4'd1;
          state_d = ST_T2;
        end else if (comp_q == 2'd2) begin
          state_d = ST_OUT;
        end else begin
          comp_d  = comp_q + 2'd1;
          bit_d   = TopBit;
          state_d = ST_T2;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          if (i_last) begin
            cnt_d   = '0;
            state_d = ST_LOAD;
          end else begin
            i_d     = i_q + AW'(1);
            state_d = ST_RD_I;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

endmodule

// ===== hdl/vns_dp.sv =====
// ----------------------------------------------------------------------------
// vns_dp
// Datapath: vertex memories, group sum, dot product, rounding root search.
// ----------------------------------------------------------------------------
module vns_dp import vns_pkg::*; #(
  parameter int unsigned MAX_VERTICES = MaxVerticesDef,
  parameter int unsigned AW = $clog2(MAX_VERTICES)
) (
  input  logic          clk_i,
  input  in_item_t      in_item_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [AW-1:0] rd_addr_i,
  input  vns_cmd_t      cmd_i,
  output out_item_t     out_item_o
);

  logic [95:0]                pos_mem [MAX_VERTICES];
  logic [47:0]                nrm_mem [MAX_VERTICES];
  logic [95:0]                rd_pos_q;
  logic [47:0]                rd_nrm_q;
  logic [95:0]                pos_i_q;
  logic                       scan_vld_q;
  logic signed [SumW-1:0]     sum_q [NumComp];
  logic [SqW-1:0]             s2_q [NumComp];
  logic [DotW-1:0]            d_q;
  logic [RootBits-1:0]        r_q;
  logic [31:0]                t2_q;
  logic [53:0]                plo_q;
  logic [53:0]                phi_q;
  logic signed [15:0]         res_q [NumComp];
  out_item_t                  out_q;
  logic signed [SumW-1:0]     sum_sel;
  logic [MagW-1:0]            mag_w;
  logic [RootBits-1:0]        cand_w;
  logic [15:0]                t_w;
  logic [75:0]                lhs_w;
  logic [75:0]                rhs_w;
  logic                       pass_w;
  logic [RootBits-1:0]        r_fin;
  logic [15:0]                r_ext;

  // Store vertices and read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      pos_mem[wr_addr_i] <= {in_item_i.pos_x, in_item_i.pos_y, in_item_i.pos_z};
      nrm_mem[wr_addr_i] <= {in_item_i.norm_x, in_item_i.norm_y, in_item_i.norm_z};
    end
    rd_pos_q <= pos_mem[rd_addr_i];
    rd_nrm_q <= nrm_mem[rd_addr_i];
  end

  // Component selection for squaring and the root search
  always_comb begin
    unique case (cmd_i.comp)
      2'd0:    sum_sel = sum_q[0];
      2'd1:    sum_sel = sum_q[1];
      default: sum_sel = sum_q[2];
    endcase
    mag_w  = sum_sel[SumW-1] ? MagW'(-sum_sel) : sum_sel[MagW-1:0];
    cand_w = r_q | (RootBits'(1) << cmd_i.bit_idx);
    t_w    = {cand_w, 1'b0} - 16'd1;
    lhs_w  = 76'(plo_q) + (76'(phi_q) << DotHalf);
    unique case (cmd_i.comp)
      2'd0:    rhs_w = 76'(s2_q[0]) << 30;
      2'd1:    rhs_w = 76'(s2_q[1]) << 30;
      default: rhs_w = 76'(s2_q[2]) << 30;
    endcase
    pass_w = (lhs_w <= rhs_w);
    r_fin  = pass_w ? cand_w : r_q;
    r_ext  = {1'b0, r_fin};
  end

  // Group sum, squares, dot product and root search steps
  always_ff @(posedge clk_i) begin
    scan_vld_q <= cmd_i.scan_rd;
    if (cmd_i.latch_i) begin
      pos_i_q <= rd_pos_q;
    end
    if (cmd_i.acc_clr) begin
      for (int c = 0; c < NumComp; c++) begin
        sum_q[c] <= '0;
      end
    end else if (scan_vld_q && (rd_pos_q == pos_i_q)) begin
      sum_q[0] <= sum_q[0] + SumW'(signed'(rd_nrm_q[47:32]));
      sum_q[1] <= sum_q[1] + SumW'(signed'(rd_nrm_q[31:16]));
      sum_q[2] <= sum_q[2] + SumW'(signed'(rd_nrm_q[15:0]));
    end
    if (cmd_i.sq_en) begin
      unique case (cmd_i.comp)
        2'd0:    s2_q[0] <= SqW'(mag_w * mag_w);
        2'd1:    s2_q[1] <= SqW'(mag_w * mag_w);
        default: s2_q[2] <= SqW'(mag_w * mag_w);
      endcase
    end
    if (cmd_i.dsum_en) begin
      d_q <= DotW'(s2_q[0]) + DotW'(s2_q[1]) + DotW'(s2_q[2]);
    end
    if (cmd_i.t2_en) begin
      t2_q <= t_w * t_w;
    end
    if (cmd_i.mul_en) begin
      plo_q <= t2_q * d_q[DotHalf-1:0];
      phi_q <= t2_q * d_q[DotW-1:DotHalf];
    end
    if (cmd_i.r_clr) begin
      r_q <= '0;
    end else if (cmd_i.cmp_en) begin
      if (cmd_i.bit_idx == 4'd0) begin
        // Finish component: zero dot product gives zero, else apply sign
        r_q <= '0;
        unique case (cmd_i.comp)
          2'd0:    res_q[0] <= (d_q == '0) ? 16'sd0 :
                               (sum_sel[SumW-1] ? -signed'(r_ext) : signed'(r_ext));
          2'd1:    res_q[1] <= (d_q == '0) ? 16'sd0 :
                               (sum_sel[SumW-1] ? -signed'(r_ext) : signed'(r_ext));
          default: res_q[2] <= (d_q == '0) ? 16'sd0 :
                               (sum_sel[SumW-1] ? -signed'(r_ext) : signed'(r_ext));
        endcase
      end else begin
        r_q <= r_fin;
      end
    end
    if (cmd_i.out_load) begin
      out_q.out_x    <= res_q[0];
      out_q.out_y    <= res_q[1];
      out_q.out_z    <= res_q[2];
      out_q.out_last <= cmd_i.out_last;
    end
  end

  assign out_item_o = out_q;

endmodule

// ===== hdl/vns_checker.sv =====
// ----------------------------------------------------------------------------
// vns_checker
// Port-level checks of the vertex normal smoother, bound to the top level.
// ----------------------------------------------------------------------------
`include "vertex_normal_smoother_macros.svh"

module vns_checker import vns_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // Hold a stalled result
  `VNS_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_stall_i, out_item_o, "result changed while stalled")

  // Stop loading after the last vertex
  `VNS_ASSERT(a_run_starts, clk_i, rst_ni, (in_valid_i && !in_stall_o && in_item_i.last_vertex) |=> in_stall_o, "input not stalled after last vertex")

  // A pending non-final result means a run is still going
  `VNS_ASSERT(a_mid_run, clk_i, rst_ni, (out_valid_o && !out_item_o.out_last) |-> in_stall_o, "loading while run unfinished")

  // The x component stays within unit range
  `VNS_ASSERT(a_unit_x, clk_i, rst_ni, out_valid_o |-> (out_item_o.out_x <= 16'sd16384 && out_item_o.out_x >= -16'sd16384), "x component out of unit range")

endmodule

bind vertex_normal_smoother vns_checker u_vns_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// ===== tb/sv/tb_vertex_normal_smoother.sv =====
// ----------------------------------------------------------------------------
// tb_vertex_normal_smoother
// Loads meshes of vertices, some sharing positions, and checks every smoothed
// normal against a local predictor of group sums and rounded normalization.
// ----------------------------------------------------------------------------
module tb_vertex_normal_smoother;
  import vns_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumVert = MaxVerticesDef;
  localparam int unsigned CycleLimit = 3000000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  vertex_normal_smoother dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // Predictor state: loaded mesh and the queue of expected normals
  in_item_t  mesh_q[$];
  out_item_t normal_q[$];
  int        mismatch_cnt;
  int        send_idle_pct;
  int        recv_idle_pct;
  bit        hold_off;
  int        cycle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Nearest-rounded component of s scaled to unit length, ties away from zero
  function automatic logic signed [15:0] unit_comp(longint s, longint d);
    longint mag;
    longint lo;
    longint hi;
    longint mid;
    longint t;
    logic [127:0] lhs;
    logic [127:0] rhs;
    mag = (s < 0) ? -s : s;
    if (d == 0) return '0;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * mid - 1;
      lhs = 128'(t * t) * 128'(d);
      rhs = (128'(mag * mag)) << 30;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (s < 0) ? 16'(-lo) : 16'(lo);
  endfunction

  // Accept one vertex into the predicted mesh; on last, predict every normal
  task automatic predict_vertex(input in_item_t v);
    longint sx, sy, sz, d;
    out_item_t r;
    if (mesh_q.size() < NumVert) mesh_q.push_back(v);
    if (!v.last_vertex) return;
    foreach (mesh_q[i]) begin
      sx = 0; sy = 0; sz = 0;
      foreach (mesh_q[j]) begin
        if (mesh_q[j].pos_x == mesh_q[i].pos_x && mesh_q[j].pos_y == mesh_q[i].pos_y &&
            mesh_q[j].pos_z == mesh_q[i].pos_z) begin
          sx += mesh_q[j].norm_x;
          sy += mesh_q[j].norm_y;
          sz += mesh_q[j].norm_z;
        end
      end
      d = sx * sx + sy * sy + sz * sz;
      r.out_x = unit_comp(sx, d);
      r.out_y = unit_comp(sy, d);
      r.out_z = unit_comp(sz, d);
      r.out_last = (i == mesh_q.size() - 1);
      normal_q.push_back(r);
    end
    mesh_q.delete();
  endtask

  // Compare each accepted normal with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (normal_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected item %p", out_item_o);
      end else begin
        e = normal_q.pop_front();
        if (out_item_o !== e) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("expected %p got %p", e, out_item_o);
        end
      end
    end
  end

  // Receiver stall: random idling, or a long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one vertex and hold it until accepted
  task automatic send_vertex(input in_item_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_vertex(v);
    // Drop valid once the mesh is complete; the block is busy with the run
    if (v.last_vertex) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Position drawn from a small pool so that groups form
  function automatic in_item_t rand_vertex(int pool, bit last);
    in_item_t v;
    int k;
    k = $urandom_range(pool);
    v.pos_x = (k == 0) ? $urandom() : 32'h3F80_0000 + k;
    v.pos_y = (k == 0) ? $urandom() : 32'hC000_0000 ^ k;
    v.pos_z = (k == 0) ? $urandom() : 32'(k * 7);
    v.norm_x = $urandom();
    v.norm_y = $urandom();
    v.norm_z = $urandom();
    if ($urandom_range(3) == 0) begin
      v.norm_x = 16'sd16384 >>> $urandom_range(3);
      v.norm_y = '0;
      v.norm_z = '0;
    end
    v.last_vertex = last;
    return v;
  endfunction

  task automatic send_mesh(int len, int pool);
    for (int i = 0; i < len; i++) send_vertex(rand_vertex(pool, i == len - 1));
  endtask

  task automatic drain();
    while (normal_q.size() != 0) @(posedge clk_i);
  endtask

  // Directed rows: vertex and, where obvious, the expected normal
  typedef struct {
    in_item_t  v;
    bit        has_exp;
    out_item_t e;
  } row_t;

  row_t table_rows[$];

  task automatic add_row(logic [31:0] p, int nx, int ny, int nz, bit last,
                         bit has_exp, int ex, int ey, int ez);
    row_t r;
    r.v = '{p, ~p, p ^ 32'hA5A5_A5A5, 16'(nx), 16'(ny), 16'(nz), last};
    r.has_exp = has_exp;
    r.e = '{16'(ex), 16'(ey), 16'(ez), last};
    table_rows.push_back(r);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    mismatch_cnt = 0;
    cycle_cnt = 0;
    hold_off = 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 67;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single vertices with extreme normals, zero sum, shared positions
    add_row(32'h0, 16384, 0, 0, 1, 1, 16384, 0, 0);
    add_row(32'hFFFF_FFFF, -32768, 0, 0, 1, 1, -16384, 0, 0);
    add_row(32'h1, 0, 0, 0, 1, 1, 0, 0, 0);
    add_row(32'h2, 0, 32767, 0, 1, 1, 0, 16384, 0);
    add_row(32'h3, 0, 0, -1, 1, 1, 0, 0, -16384);
    add_row(32'h4, 100, 0, 0, 0, 0, 0, 0, 0);
    add_row(32'h4, -100, 0, 0, 0, 0, 0, 0, 0);
    add_row(32'h5, 32767, 32767, 32767, 0, 0, 0, 0, 0);
    add_row(32'h4, 0, 5, 0, 0, 0, 0, 0, 0);
    add_row(32'h5, -32768, -32768, -32768, 1, 0, 0, 0, 0);
    add_row(32'h8000_0000, 3, 4, 0, 1, 0, 0, 0, 0);
    foreach (table_rows[i]) begin
      send_vertex(table_rows[i].v);
      if (table_rows[i].has_exp && normal_q.size() != 0 &&
          normal_q[normal_q.size() - 1] !== table_rows[i].e) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("predicted %p, row says %p", normal_q[normal_q.size() - 1],
                   table_rows[i].e);
      end
    end
    drain();

    // Full store plus dropped vertices, the last one among the dropped
    send_mesh(NumVert + 3, 20);
    drain();

    // Random meshes under three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 67 : 0;
      recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 24 : 0;
      for (int m = 0; m < 8; m++) send_mesh($urandom_range(14, 1), $urandom_range(6, 1));
      // Pause until every expected normal has come
      drain();
    end

    // Long receiver hold-off while the sender keeps offering vertices
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_mesh(5, 2);
        send_mesh(4, 2);
      end
    join
    drain();
    repeat (400) @(posedge clk_i);

    if (mismatch_cnt == 0 && normal_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
